>>> rtl/ebc_pkg.sv
package ebc_pkg;

  // default width of the position counter
  localparam int COUNT_BITS_DEF = 16;

  // field widths
  localparam int POS_W   = 16;
  localparam int TGT_W   = 16;
  localparam int DB_W    = 8;
  localparam int LIM_W   = 15;
  localparam int DRIVE_W = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd2;

  // register reset values
  localparam logic signed [TGT_W-1:0] TARGET_RST   = 16'sd100;
  localparam logic [DB_W-1:0]         DEADBAND_RST = 8'd4;
  localparam logic [LIM_W-1:0]        LIMIT_RST    = 15'd300;

  // drive codes
  localparam logic [DRIVE_W-1:0] DRIVE_STOP = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_CW   = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_CCW  = 2'd2;

  typedef struct packed {
    logic chan_a;
    logic chan_b;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [DRIVE_W-1:0]      drive;
    logic                    pulse_seen;
  } out_item_t;

endpackage

>>> rtl/encoder_position_bang_controller_core.sv
// Quadrature encoder counter with bang-bang position drive. Each request is one
// poll of channels A and B; every request gives exactly one result carrying the
// saturating position count, the motor drive (stop, clockwise, counter-clockwise)
// and a flag for a step on channel A. A request is held in an input register,
// where the count step and the drive compares are done, and the result lands
// in an output register; one request is taken per clock while out_ready does
// not stall the output register, and the count register loop sets that rate.
// The first request after reset only records the level of A and returns stop.
// Configuration writes (target, deadband, travel limit) take effect at once and
// are expected only while no request is in flight.
module encoder_position_bang_controller_core
  import ebc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // compare width covers the count, the target and the limits with headroom
  localparam int CW = ((COUNT_BITS > TGT_W) ? COUNT_BITS : TGT_W) + 2;
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic signed [TGT_W-1:0]      target_r;
  logic [DB_W-1:0]              deadband_r;
  logic [LIM_W-1:0]             limit_r;

  logic                         in_valid_r;
  in_item_t                     in_data_r;
  logic                         out_valid_r;
  out_item_t                    out_data_r;

  logic                         prev_a_r;
  logic                         primed_r;
  logic signed [COUNT_BITS-1:0] count_r;
  logic                         dir_cw_r;

  logic                         advance;
  logic                         fire;
  logic                         pulse;
  logic signed [COUNT_BITS-1:0] count_nxt;
  logic                         dir_cw_nxt;
  logic [DRIVE_W-1:0]           drive;
  out_item_t                    out_nxt;

  logic signed [CW-1:0]         cnt_ext;
  logic signed [CW-1:0]         tgt_ext;
  logic signed [CW-1:0]         db_ext;
  logic signed [CW-1:0]         lim_ext;
  logic                         in_band;
  logic                         past_limit;

  // handshake: output register frees the compute stage, which frees the input register
  assign advance   = !out_valid_r || out_ready;
  assign fire      = in_valid_r && advance;
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= TARGET_RST;
      deadband_r <= DEADBAND_RST;
      limit_r    <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TARGET:   target_r   <= $signed(cfg_data[TGT_W-1:0]);
        REG_DEADBAND: deadband_r <= cfg_data[DB_W-1:0];
        REG_LIMIT:    limit_r    <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // count step on a change of channel A, saturating at the counter limits
  always_comb begin
    pulse     = primed_r && (in_data_r.chan_a != prev_a_r);
    count_nxt = count_r;
    if (pulse) begin
      if (in_data_r.chan_b != in_data_r.chan_a) begin
        if (count_r != CNT_MAX) count_nxt = count_r + COUNT_BITS'(1);
      end else begin
        if (count_r != CNT_MIN) count_nxt = count_r - COUNT_BITS'(1);
      end
    end
  end

  // drive decision from the stepped count
  assign cnt_ext    = CW'(count_nxt);
  assign tgt_ext    = CW'(target_r);
  assign db_ext     = $signed(CW'(deadband_r));
  assign lim_ext    = $signed(CW'(limit_r));
  assign in_band    = (cnt_ext > tgt_ext - db_ext) && (cnt_ext < tgt_ext + db_ext);
  assign past_limit = (cnt_ext > lim_ext) || (cnt_ext < -lim_ext);

  always_comb begin
    drive      = DRIVE_STOP;
    dir_cw_nxt = dir_cw_r;
    if (primed_r && !in_band) begin
      if (past_limit) begin
        drive      = dir_cw_r ? DRIVE_CCW : DRIVE_CW;
        dir_cw_nxt = !dir_cw_r;
      end else if (cnt_ext < tgt_ext) begin
        drive      = DRIVE_CW;
        dir_cw_nxt = 1'b1;
      end else if (cnt_ext > tgt_ext) begin
        drive      = DRIVE_CCW;
        dir_cw_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_nxt.position   = cnt_ext[POS_W-1:0];
    out_nxt.drive      = drive;
    out_nxt.pulse_seen = pulse;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // encoder state, updated as each request passes the compute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b0;
      primed_r <= 1'b0;
      count_r  <= '0;
      dir_cw_r <= 1'b1;
    end else if (fire) begin
      prev_a_r <= in_data_r.chan_a;
      primed_r <= 1'b1;
      count_r  <= count_nxt;
      dir_cw_r <= dir_cw_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_nxt;
    end
  end

  // first request after reset only primes channel A
  a_prime_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !primed_r) |=> (out_data_r.pulse_seen == 1'b0 && out_data_r.drive == DRIVE_STOP))
    else $error("priming request produced a pulse or a drive");

  // the count moves only on a pulse
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !pulse) |=> $stable(count_r))
    else $error("count moved without a pulse");

  // a stop result keeps the direction flag
  a_stop_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && drive == DRIVE_STOP) |=> $stable(dir_cw_r))
    else $error("direction changed on a stop");

  // direction flag follows the drive issued
  a_dir_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (drive == DRIVE_CW || drive == DRIVE_CCW)) |=> (dir_cw_r == (out_data_r.drive == DRIVE_CW)))
    else $error("direction flag disagrees with drive");

  // result register holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule
